// File: hw/rtl/scsa_pkg.sv
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared constants, codes, memory port types and helpers for the size-class
// slab allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

    localparam int SLAB_BYTES  = 65536;
    localparam int SLAB_SHIFT  = $clog2(SLAB_BYTES);
    localparam int SLAB_COUNT  = 4;
    localparam int CLASS_COUNT = 7;
    localparam int HDR_BYTES   = 16;

    localparam int STORE_DEPTH = SLAB_COUNT * SLAB_BYTES / HDR_BYTES;
    localparam int GRAN_W      = $clog2(STORE_DEPTH);
    localparam int LINK_W      = GRAN_W + 1;
    localparam int CLS_W       = 3;
    localparam int CB_W        = 5 + CLASS_COUNT;
    localparam int CAP_W       = 11;
    localparam int SIZE_W      = 32;
    localparam int ADDR_W      = 18;
    localparam int CARVE_W     = ADDR_W + 1;
    localparam int REM_W       = 17;
    localparam int OPEN_W      = 3;
    localparam int LIMIT_W     = 3;
    localparam int ACT_W       = 2;
    localparam int STAT_W      = 2;

    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 40;

    localparam logic [LIMIT_W-1:0] SLAB_LIMIT_RESET = 3'd4;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC_ZERO = 2'd0,
        ACT_ALLOC      = 2'd1,
        ACT_RESIZE     = 2'd2,
        ACT_FREE       = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EXHAUSTED = 2'd1,
        STAT_TOO_BIG   = 2'd2
    } status_t;

    typedef struct packed {
        logic              we;
        logic [GRAN_W-1:0] addr;
        logic [LINK_W-1:0] wdata;
    } link_port_t;

    typedef struct packed {
        logic              we;
        logic [GRAN_W-1:0] addr;
        logic [CLS_W-1:0]  wdata;
    } class_port_t;

    function automatic logic [CB_W-1:0] class_span(input logic [CLS_W-1:0] idx);
        class_span = CB_W'(32) << idx;
    endfunction

    function automatic logic [CAP_W-1:0] class_cap(input logic [CLS_W-1:0] idx);
        logic [CB_W-1:0] full;
        full      = class_span(idx) - CB_W'(HDR_BYTES);
        class_cap = full[CAP_W-1:0];
    endfunction

endpackage

// File: hw/rtl/scsa_ram.sv
// ----------------------------------------------------------------------------
// scsa_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module scsa_ram #(
    parameter int WIDTH = scsa_pkg::LINK_W,
    parameter int DEPTH = scsa_pkg::STORE_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/scsa_ctrl.sv
// ----------------------------------------------------------------------------
// scsa_ctrl
// Request sequencer: class lookup, free-list heads, slab carving and the
// result register. Drives the link and class RAM ports.
// ----------------------------------------------------------------------------
module scsa_ctrl (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [scsa_pkg::LIMIT_W-1:0]          slab_limit,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [scsa_pkg::ACT_W-1:0]            s_action,
    input  logic [scsa_pkg::SIZE_W-1:0]           s_size,
    input  logic [scsa_pkg::ADDR_W-1:0]           s_address,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [scsa_pkg::STAT_W-1:0]           m_status,
    output logic [scsa_pkg::ADDR_W-1:0]           m_result_address,
    output logic [scsa_pkg::CLS_W-1:0]            m_class_index,
    output logic                                  m_clear_needed,
    output logic [scsa_pkg::CAP_W-1:0]            m_copy_bytes,
    output scsa_pkg::link_port_t                  link_port,
    input  logic [scsa_pkg::LINK_W-1:0]           link_rdata,
    output scsa_pkg::class_port_t                 class_port,
    input  logic [scsa_pkg::CLS_W-1:0]            class_rdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_POP,
        ST_PUSH
    } state_t;

    state_t                           state_reg, state_next;
    logic [scsa_pkg::ACT_W-1:0]       act_reg, act_next;
    logic [scsa_pkg::SIZE_W-1:0]      size_reg, size_next;
    logic [scsa_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic [scsa_pkg::GRAN_W-1:0]      gran_reg, gran_next;
    logic [scsa_pkg::CLS_W-1:0]       cls_reg, cls_next;
    logic                             big_reg, big_next;
    logic [scsa_pkg::CLS_W-1:0]       old_reg, old_next;

    logic                             head_valid_reg [scsa_pkg::CLASS_COUNT];
    logic                             head_valid_next [scsa_pkg::CLASS_COUNT];
    logic [scsa_pkg::GRAN_W-1:0]      head_idx_reg [scsa_pkg::CLASS_COUNT];
    logic [scsa_pkg::GRAN_W-1:0]      head_idx_next [scsa_pkg::CLASS_COUNT];

    logic [scsa_pkg::CARVE_W-1:0]     carve_reg, carve_next;
    logic [scsa_pkg::REM_W-1:0]       rem_reg, rem_next;
    logic [scsa_pkg::OPEN_W-1:0]      opened_reg, opened_next;

    logic                             m_valid_reg, m_valid_next;
    logic [scsa_pkg::STAT_W-1:0]      m_status_reg, m_status_next;
    logic [scsa_pkg::ADDR_W-1:0]      m_addr_reg, m_addr_next;
    logic [scsa_pkg::CLS_W-1:0]       m_cls_reg, m_cls_next;
    logic                             m_clear_reg, m_clear_next;
    logic [scsa_pkg::CAP_W-1:0]       m_copy_reg, m_copy_next;

    logic                             accept;
    logic                             out_free;
    logic                             load;
    logic [scsa_pkg::SIZE_W-1:0]      alloc_size;
    logic [scsa_pkg::SIZE_W:0]        total;
    logic [scsa_pkg::CLS_W-1:0]       cls_calc;
    logic                             big_calc;
    logic [scsa_pkg::GRAN_W-1:0]      s_gran;
    logic [scsa_pkg::CLS_W-1:0]       old_cls;
    logic [scsa_pkg::CAP_W-1:0]       cap_look;
    logic [scsa_pkg::CAP_W-1:0]       cap_pop;
    logic                             fits;
    logic [scsa_pkg::CLS_W-1:0]       hsel;
    logic                             hv;
    logic [scsa_pkg::GRAN_W-1:0]      hi;
    logic [scsa_pkg::REM_W-1:0]       need;
    logic                             open_new;
    logic [scsa_pkg::OPEN_W-1:0]      limit;
    logic                             exhausted;
    logic [scsa_pkg::CARVE_W-1:0]     start;
    logic [scsa_pkg::REM_W-1:0]       rem_base;
    logic [scsa_pkg::CARVE_W-1:0]     start_usable;
    logic [scsa_pkg::ADDR_W-1:0]      pop_addr;
    logic                             is_resize;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign is_resize = (act_reg == scsa_pkg::ACT_RESIZE);

    // size class of an incoming request
    always_comb begin
        alloc_size = s_size;
        if (s_action != scsa_pkg::ACT_RESIZE && s_size == '0) begin
            alloc_size = scsa_pkg::SIZE_W'(1);
        end
        total    = {1'b0, alloc_size} + (scsa_pkg::SIZE_W+1)'(scsa_pkg::HDR_BYTES);
        cls_calc = '0;
        big_calc = 1'b1;
        for (int i = scsa_pkg::CLASS_COUNT - 1; i >= 0; i--) begin
            if (total <= (scsa_pkg::SIZE_W+1)'(scsa_pkg::class_span(scsa_pkg::CLS_W'(i))))
            begin
                cls_calc = scsa_pkg::CLS_W'(i);
                big_calc = 1'b0;
            end
        end
    end

    assign s_gran = s_address[scsa_pkg::ADDR_W-1:4] - scsa_pkg::GRAN_W'(1);

    assign old_cls  = (class_rdata < scsa_pkg::CLS_W'(scsa_pkg::CLASS_COUNT)) ?
                      class_rdata : '0;
    assign cap_look = scsa_pkg::class_cap(old_cls);
    assign cap_pop  = scsa_pkg::class_cap(old_reg);
    assign fits     = (size_reg <= scsa_pkg::SIZE_W'(cap_look));

    always_comb begin
        case (state_reg)
            ST_PUSH: hsel = old_reg;
            ST_LOOK: hsel = (act_reg == scsa_pkg::ACT_FREE) ? old_cls : cls_reg;
            default: hsel = cls_reg;
        endcase
    end

    assign hv = head_valid_reg[hsel];
    assign hi = head_idx_reg[hsel];

    // slab carving
    assign need      = scsa_pkg::REM_W'(scsa_pkg::class_span(cls_reg));
    assign open_new  = (rem_reg < need);
    assign limit     = (slab_limit > scsa_pkg::OPEN_W'(scsa_pkg::SLAB_COUNT)) ?
                       scsa_pkg::OPEN_W'(scsa_pkg::SLAB_COUNT) : slab_limit;
    assign exhausted = open_new && (opened_reg >= limit);
    assign start     = open_new ?
                       ((scsa_pkg::CARVE_W'(opened_reg) << scsa_pkg::SLAB_SHIFT)
                        + scsa_pkg::CARVE_W'(scsa_pkg::HDR_BYTES)) : carve_reg;
    assign rem_base  = open_new ?
                       scsa_pkg::REM_W'(scsa_pkg::SLAB_BYTES - scsa_pkg::HDR_BYTES) : rem_reg;
    assign start_usable = start + scsa_pkg::CARVE_W'(scsa_pkg::HDR_BYTES);
    assign pop_addr  = scsa_pkg::ADDR_W'({hi, 4'b0000})
                       + scsa_pkg::ADDR_W'(scsa_pkg::HDR_BYTES);

    always_comb begin
        state_next  = state_reg;
        act_next    = act_reg;
        size_next   = size_reg;
        addr_next   = addr_reg;
        gran_next   = gran_reg;
        cls_next    = cls_reg;
        big_next    = big_reg;
        old_next    = old_reg;
        head_valid_next = head_valid_reg;
        head_idx_next   = head_idx_reg;
        carve_next  = carve_reg;
        rem_next    = rem_reg;
        opened_next = opened_reg;

        load          = 1'b0;
        m_status_next = m_status_reg;
        m_addr_next   = m_addr_reg;
        m_cls_next    = m_cls_reg;
        m_clear_next  = m_clear_reg;
        m_copy_next   = m_copy_reg;

        link_port.we    = 1'b0;
        link_port.addr  = hi;
        link_port.wdata = {hv, hi};

        class_port.we    = 1'b0;
        class_port.addr  = (state_reg == ST_IDLE) ? s_gran : gran_reg;
        class_port.wdata = cls_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    act_next   = s_action;
                    size_next  = s_size;
                    addr_next  = s_address;
                    gran_next  = s_gran;
                    cls_next   = cls_calc;
                    big_next   = big_calc;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (out_free) begin
                    old_next      = old_cls;
                    m_status_next = scsa_pkg::STAT_OK;
                    m_addr_next   = '0;
                    m_cls_next    = '0;
                    m_clear_next  = 1'b0;
                    m_copy_next   = '0;
                    if (act_reg == scsa_pkg::ACT_FREE) begin
                        link_port.we   = 1'b1;
                        link_port.addr = gran_reg;
                        head_valid_next[old_cls] = 1'b1;
                        head_idx_next[old_cls]   = gran_reg;
                        load       = 1'b1;
                        state_next = ST_IDLE;
                    end else if (is_resize && fits) begin
                        m_addr_next = addr_reg;
                        m_cls_next  = old_cls;
                        load        = 1'b1;
                        state_next  = ST_IDLE;
                    end else if (big_reg) begin
                        m_status_next = scsa_pkg::STAT_TOO_BIG;
                        load          = 1'b1;
                        state_next    = ST_IDLE;
                    end else if (hv) begin
                        state_next = ST_POP;
                    end else if (exhausted) begin
                        m_status_next = scsa_pkg::STAT_EXHAUSTED;
                        load          = 1'b1;
                        state_next    = ST_IDLE;
                    end else begin
                        carve_next  = start + scsa_pkg::CARVE_W'(need);
                        rem_next    = rem_base - need;
                        if (open_new) begin
                            opened_next = opened_reg + scsa_pkg::OPEN_W'(1);
                        end
                        class_port.we   = 1'b1;
                        class_port.addr = start[scsa_pkg::GRAN_W+3:4];
                        m_addr_next = start_usable[scsa_pkg::ADDR_W-1:0];
                        m_cls_next  = cls_reg;
                        m_copy_next = is_resize ? cap_look : '0;
                        load        = 1'b1;
                        state_next  = is_resize ? ST_PUSH : ST_IDLE;
                    end
                end
            end
            ST_POP: begin
                if (out_free) begin
                    head_valid_next[cls_reg] = link_rdata[scsa_pkg::LINK_W-1];
                    head_idx_next[cls_reg]   = link_rdata[scsa_pkg::GRAN_W-1:0];
                    class_port.we   = 1'b1;
                    class_port.addr = hi;
                    m_status_next = scsa_pkg::STAT_OK;
                    m_addr_next   = pop_addr;
                    m_cls_next    = cls_reg;
                    m_clear_next  = (act_reg == scsa_pkg::ACT_ALLOC_ZERO);
                    m_copy_next   = is_resize ? cap_pop : '0;
                    load          = 1'b1;
                    state_next    = is_resize ? ST_PUSH : ST_IDLE;
                end
            end
            ST_PUSH: begin
                link_port.we   = 1'b1;
                link_port.addr = gran_reg;
                head_valid_next[old_reg] = 1'b1;
                head_idx_next[old_reg]   = gran_reg;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = (m_valid_reg && !m_tready) || load;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            carve_reg   <= '0;
            rem_reg     <= '0;
            opened_reg  <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < scsa_pkg::CLASS_COUNT; i++) begin
                head_valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg   <= state_next;
            carve_reg   <= carve_next;
            rem_reg     <= rem_next;
            opened_reg  <= opened_next;
            m_valid_reg <= m_valid_next;
            head_valid_reg <= head_valid_next;
        end
        act_reg      <= act_next;
        size_reg     <= size_next;
        addr_reg     <= addr_next;
        gran_reg     <= gran_next;
        cls_reg      <= cls_next;
        big_reg      <= big_next;
        old_reg      <= old_next;
        head_idx_reg <= head_idx_next;
        m_status_reg <= m_status_next;
        m_addr_reg   <= m_addr_next;
        m_cls_reg    <= m_cls_next;
        m_clear_reg  <= m_clear_next;
        m_copy_reg   <= m_copy_next;
    end

    assign m_tvalid         = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_result_address = m_addr_reg;
    assign m_class_index    = m_cls_reg;
    assign m_clear_needed   = m_clear_reg;
    assign m_copy_bytes     = m_copy_reg;

endmodule

// File: hw/rtl/size_class_slab_allocator_core.sv
// ----------------------------------------------------------------------------
// size_class_slab_allocator_core
// Slab allocator with power-of-two size classes, per-class LIFO free lists
// kept in a link RAM, and a class RAM recording each block's class.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. A free, a resize that fits, a
// carved allocation or a rejected request is settled in ST_LOOK; an
// allocation served from a free list goes on to ST_POP, since the list head
// is replaced only after the link RAM read returns. A resize that moves the
// block pushes the old block in ST_PUSH after its result is loaded. The
// next request is taken once that work is done, even while the last result
// is still waiting on m_tready; a result that cannot be placed holds the
// sequencer. The link RAM needs no clearing pass: its entries are read only
// after they are written. Class RAM codes out of range are taken as 0.
module size_class_slab_allocator_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // slab_limit
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scsa_pkg::LIMIT_W-1:0]      cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [31:0] size, [49:32] address
    input  logic [scsa_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] action
    input  logic [scsa_pkg::ACT_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [17:0] result_address, [20:18] class_index, [21] clear_needed,
    // [32:22] copy_bytes
    output logic [scsa_pkg::M_TDATA_W-1:0]    m_tdata,
    // [1:0] status
    output logic [scsa_pkg::STAT_W-1:0]       m_tuser
);

    logic [scsa_pkg::LIMIT_W-1:0]  slab_limit_reg;
    scsa_pkg::link_port_t          link_port;
    scsa_pkg::class_port_t         class_port;
    logic [scsa_pkg::LINK_W-1:0]   link_rdata;
    logic [scsa_pkg::CLS_W-1:0]    class_rdata;
    logic [scsa_pkg::ADDR_W-1:0]   m_result_address;
    logic [scsa_pkg::CLS_W-1:0]    m_class_index;
    logic                          m_clear_needed;
    logic [scsa_pkg::CAP_W-1:0]    m_copy_bytes;

    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slab_limit_reg <= scsa_pkg::SLAB_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            slab_limit_reg <= cfg_data;
        end
    end

    scsa_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .slab_limit       (slab_limit_reg),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_action         (s_tuser),
        .s_size           (s_tdata[scsa_pkg::SIZE_W-1:0]),
        .s_address        (s_tdata[scsa_pkg::SIZE_W+scsa_pkg::ADDR_W-1:scsa_pkg::SIZE_W]),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_status         (m_tuser),
        .m_result_address (m_result_address),
        .m_class_index    (m_class_index),
        .m_clear_needed   (m_clear_needed),
        .m_copy_bytes     (m_copy_bytes),
        .link_port        (link_port),
        .link_rdata       (link_rdata),
        .class_port       (class_port),
        .class_rdata      (class_rdata)
    );

    scsa_ram #(
        .WIDTH (scsa_pkg::LINK_W),
        .DEPTH (scsa_pkg::STORE_DEPTH),
        .AW    (scsa_pkg::GRAN_W)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_port.we),
        .addr  (link_port.addr),
        .wdata (link_port.wdata),
        .rdata (link_rdata)
    );

    scsa_ram #(
        .WIDTH (scsa_pkg::CLS_W),
        .DEPTH (scsa_pkg::STORE_DEPTH),
        .AW    (scsa_pkg::GRAN_W)
    ) u_class_ram (
        .aclk  (aclk),
        .we    (class_port.we),
        .addr  (class_port.addr),
        .wdata (class_port.wdata),
        .rdata (class_rdata)
    );

    assign m_tdata = {
        (scsa_pkg::M_TDATA_W - scsa_pkg::CAP_W - 1 - scsa_pkg::CLS_W - scsa_pkg::ADDR_W)'(0),
        m_copy_bytes,
        m_clear_needed,
        m_class_index,
        m_result_address
    };

endmodule

// File: test/slab_ledger_pkg.sv
// ----------------------------------------------------------------------------
// slab_ledger_pkg
// Tracks the allocator's free lists, carve state and block classes, predicts
// the reply to every accepted request and checks replies in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package slab_ledger_pkg;

    import scsa_pkg::*;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] addr;
        logic [CLS_W-1:0]  cls;
        logic              clear;
        logic [CAP_W-1:0]  copy;
    } alloc_reply_t;

    class slab_ledger;
        bit               head_valid [CLASS_COUNT];
        int unsigned      head_gran  [CLASS_COUNT];
        bit               next_valid [STORE_DEPTH];
        int unsigned      next_gran  [STORE_DEPTH];
        logic [CLS_W-1:0] gran_class [STORE_DEPTH];
        bit               gran_seen  [STORE_DEPTH];
        int unsigned      seen_grans [$];
        longint unsigned  carve_ptr;
        longint unsigned  slab_left;
        int unsigned      slabs_open;
        int unsigned      slab_limit;
        alloc_reply_t     owed [$];
        int unsigned      errors;

        function new();
            carve_ptr  = 0;
            slab_left  = 0;
            slabs_open = 0;
            slab_limit = SLAB_LIMIT_RESET;
            errors     = 0;
        endfunction

        function int unsigned granule_of(logic [ADDR_W-1:0] address);
            longint unsigned start;
            start = {46'd0, address} - 64'd16;
            return int'((start >> 4) % STORE_DEPTH);
        endfunction

        function logic [CLS_W-1:0] class_at(int unsigned g);
            if (gran_class[g] < CLASS_COUNT) return gran_class[g];
            return '0;
        endfunction

        function void push_block(logic [CLS_W-1:0] cls, int unsigned g);
            next_valid[g]   = head_valid[cls];
            next_gran[g]    = head_gran[cls];
            head_valid[cls] = 1'b1;
            head_gran[cls]  = g;
        endfunction

        // pop the class list or carve; leave state untouched on failure
        function status_t grant_block(longint unsigned bytes, output logic [ADDR_W-1:0] addr,
                                      output logic [CLS_W-1:0] cls, output bit reused);
            longint unsigned total;
            longint unsigned start;
            longint unsigned need;
            int unsigned     i;
            int unsigned     g;
            int unsigned     lim;
            addr   = '0;
            cls    = '0;
            reused = 1'b0;
            total  = bytes + 64'd16;
            i      = 0;
            while (i < CLASS_COUNT && (64'd32 << i) < total) i++;
            if (i >= CLASS_COUNT) return STAT_TOO_BIG;
            if (head_valid[i]) begin
                g             = head_gran[i] % STORE_DEPTH;
                head_valid[i] = next_valid[g];
                head_gran[i]  = next_gran[g];
                start         = 64'(g) * 64'd16;
                reused        = 1'b1;
            end else begin
                need = 64'd32 << i;
                if (slab_left < need) begin
                    lim = (slab_limit < SLAB_COUNT) ? slab_limit : SLAB_COUNT;
                    if (slabs_open >= lim) return STAT_EXHAUSTED;
                    carve_ptr = 64'(slabs_open) * 64'(SLAB_BYTES) + 64'd16;
                    slab_left = 64'(SLAB_BYTES) - 64'd16;
                    slabs_open++;
                end
                start      = carve_ptr;
                carve_ptr += need;
                slab_left -= need;
            end
            g             = int'((start >> 4) % STORE_DEPTH);
            gran_class[g] = CLS_W'(i);
            if (!gran_seen[g]) begin
                gran_seen[g] = 1'b1;
                seen_grans.push_back(g);
            end
            addr = ADDR_W'(start + 64'd16);
            cls  = CLS_W'(i);
            return STAT_OK;
        endfunction

        function alloc_reply_t record_request(action_t act, logic [SIZE_W-1:0] size,
                                              logic [ADDR_W-1:0] address);
            alloc_reply_t      r;
            int unsigned       g;
            logic [CLS_W-1:0]  old;
            longint unsigned   cap;
            logic [ADDR_W-1:0] a;
            logic [CLS_W-1:0]  c;
            bit                reused;
            r = '0;
            case (act)
                ACT_ALLOC_ZERO, ACT_ALLOC: begin
                    r.status = grant_block((size == 0) ? 32'd1 : size, a, c, reused);
                    if (r.status == STAT_OK) begin
                        r.addr  = a;
                        r.cls   = c;
                        r.clear = (act == ACT_ALLOC_ZERO) && reused;
                    end
                end
                ACT_RESIZE: begin
                    g   = granule_of(address);
                    old = class_at(g);
                    cap = (64'd32 << old) - 64'd16;
                    if (64'(size) <= cap) begin
                        r.addr = address;
                        r.cls  = old;
                    end else begin
                        r.status = grant_block(size, a, c, reused);
                        if (r.status == STAT_OK) begin
                            r.addr = a;
                            r.cls  = c;
                            r.copy = CAP_W'(cap);
                            push_block(old, g);
                        end
                    end
                end
                default: begin
                    g = granule_of(address);
                    push_block(class_at(g), g);
                end
            endcase
            owed.push_back(r);
            return r;
        endfunction

        function void check_reply(logic [M_TDATA_W-1:0] data, logic [STAT_W-1:0] user);
            alloc_reply_t      want;
            logic [ADDR_W-1:0] got_addr;
            logic [CLS_W-1:0]  got_cls;
            logic              got_clear;
            logic [CAP_W-1:0]  got_copy;
            got_addr  = data[ADDR_W-1:0];
            got_cls   = data[ADDR_W +: CLS_W];
            got_clear = data[ADDR_W + CLS_W];
            got_copy  = data[ADDR_W + CLS_W + 1 +: CAP_W];
            if (owed.size() == 0) begin
                $error("unexpected transaction: status %0d, result_address 0x%0h",
                       user, got_addr);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (user !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, user);
                errors++;
            end
            if (got_addr !== want.addr) begin
                $error("result_address: expected 0x%0h, got 0x%0h", want.addr, got_addr);
                errors++;
            end
            if (got_cls !== want.cls) begin
                $error("class_index: expected %0d, got %0d", want.cls, got_cls);
                errors++;
            end
            if (got_clear !== want.clear) begin
                $error("clear_needed: expected %0b, got %0b", want.clear, got_clear);
                errors++;
            end
            if (got_copy !== want.copy) begin
                $error("copy_bytes: expected %0d, got %0d", want.copy, got_copy);
                errors++;
            end
        endfunction
    endclass

endpackage

// File: test/size_class_slab_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// size_class_slab_allocator_core_tb
// Drives allocate, resize and free transactions through the allocator under
// several slab limits and idle patterns, and checks every reply against a
// running model of the free lists and slab carving.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module size_class_slab_allocator_core_tb;

    import scsa_pkg::*;
    import slab_ledger_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_LIMIT [PHASES] = '{1, 0, 2, 3, 7, 4};
    localparam int unsigned PHASE_ITEMS [PHASES] = '{300, 80, 350, 350, 200, 320};

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [LIMIT_W-1:0]    cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [ACT_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STAT_W-1:0]     m_tuser;

    slab_ledger            ledger;
    int unsigned           send_idle_pct;
    int unsigned           recv_stall_pct;
    int unsigned           cycle_count;
    bit                    allow_stale;
    logic [ADDR_W-1:0]     live_blocks [$];

    size_class_slab_allocator_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("size_class_slab_allocator_core verification failed");
            $finish;
        end else if (aresetn && m_tvalid && m_tready) begin
            ledger.check_reply(m_tdata, m_tuser);
        end
    end

    task automatic send_request(input action_t act, input logic [SIZE_W-1:0] size,
                                input logic [ADDR_W-1:0] address, output alloc_reply_t reply);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= S_TDATA_W'({address, size});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        reply = ledger.record_request(act, size, address);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (ledger.owed.size() != 0);
    endtask

    task automatic write_slab_limit(input logic [LIMIT_W-1:0] value);
        drain_results();
        // let a moved resize finish pushing the old block
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        ledger.slab_limit = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SIZE_W-1:0] size_in_class(int unsigned c);
        int unsigned lo;
        int unsigned hi;
        hi = (32 << c) - HDR_BYTES;
        lo = (c == 0) ? 0 : (32 << (c - 1)) - HDR_BYTES + 1;
        return $urandom_range(hi, lo);
    endfunction

    function automatic logic [SIZE_W-1:0] oversize();
        if ($urandom_range(1) == 0) return $urandom_range(32'hFFFF_FFFF, 2033);
        return $urandom_range(4095, 2033);
    endfunction

    function automatic logic [SIZE_W-1:0] alloc_size();
        if ($urandom_range(99) < 40) return size_in_class(CLASS_COUNT - 1);
        return size_in_class($urandom_range(CLASS_COUNT - 1));
    endfunction

    function automatic logic [SIZE_W-1:0] resize_size();
        int unsigned r;
        r = $urandom_range(19);
        if (r == 0) return '0;
        if (r == 1) return oversize();
        return alloc_size();
    endfunction

    function automatic logic [ADDR_W-1:0] jitter();
        if ($urandom_range(3) == 0) return ADDR_W'($urandom_range(15));
        return '0;
    endfunction

    task automatic run_directed();
        alloc_reply_t      r;
        logic [ADDR_W-1:0] blk_a;
        logic [ADDR_W-1:0] blk_b;
        logic [ADDR_W-1:0] blk_c;
        logic [ADDR_W-1:0] blk_d;
        send_request(ACT_ALLOC, 32'd0, '0, r);
        blk_a = r.addr;
        send_request(ACT_ALLOC_ZERO, 32'd16, '1, r);
        blk_b = r.addr;
        send_request(ACT_ALLOC, 32'd17, '0, r);
        blk_c = r.addr;
        send_request(ACT_ALLOC_ZERO, 32'd2032, '0, r);
        blk_d = r.addr;
        send_request(ACT_ALLOC, 32'd2033, '0, r);
        send_request(ACT_ALLOC_ZERO, 32'hFFFF_FFFF, '1, r);
        send_request(ACT_RESIZE, 32'd0, blk_a, r);
        send_request(ACT_RESIZE, 32'd16, blk_a + 18'd15, r);
        send_request(ACT_RESIZE, 32'd100, blk_a, r);
        blk_a = r.addr;
        send_request(ACT_FREE, 32'd0, blk_c, r);
        send_request(ACT_ALLOC_ZERO, 32'd20, '0, r);
        blk_c = r.addr;
        send_request(ACT_FREE, 32'hFFFF_FFFF, blk_b + 18'd7, r);
        send_request(ACT_ALLOC, 32'd1, '0, r);
        blk_b = r.addr;
        // double free of a small block, then pop it twice
        send_request(ACT_FREE, 32'd0, blk_b, r);
        send_request(ACT_FREE, 32'd0, blk_b, r);
        send_request(ACT_ALLOC_ZERO, 32'd5, '0, r);
        send_request(ACT_ALLOC_ZERO, 32'd5, '0, r);
        send_request(ACT_RESIZE, 32'd2032, blk_d, r);
        send_request(ACT_RESIZE, 32'd2033, blk_d, r);
        send_request(ACT_RESIZE, 32'hFFFF_FFFF, blk_c, r);
        send_request(ACT_RESIZE, 32'd500, blk_c, r);
        send_request(ACT_FREE, 32'd0, blk_d, r);
        send_request(ACT_FREE, 32'd0, blk_a, r);
    endtask

    task automatic run_random(input int unsigned count);
        alloc_reply_t      reply;
        int unsigned       n;
        int unsigned       pick;
        int unsigned       slot;
        int unsigned       g;
        logic [ADDR_W-1:0] where;
        action_t           act;
        for (n = 0; n < count; n++) begin
            if (n == count / 2 || $urandom_range(149) == 0) drain_results();
            pick = $urandom_range(99);
            act  = ($urandom_range(1) == 0) ? ACT_ALLOC_ZERO : ACT_ALLOC;
            if (allow_stale && pick >= 97 && ledger.seen_grans.size() != 0) begin
                g     = ledger.seen_grans[$urandom_range(ledger.seen_grans.size() - 1)];
                where = ADDR_W'(g * HDR_BYTES + HDR_BYTES) + jitter();
                if ($urandom_range(1) == 0) send_request(ACT_FREE, $urandom(), where, reply);
                else send_request(ACT_RESIZE, resize_size(), where, reply);
            end else if (pick < 55 || live_blocks.size() == 0) begin
                send_request(act, (pick < 5) ? oversize() : alloc_size(),
                             ADDR_W'($urandom()), reply);
                if (reply.status == STAT_OK) live_blocks.push_back(reply.addr);
            end else begin
                slot  = $urandom_range(live_blocks.size() - 1);
                where = live_blocks[slot] + jitter();
                if (pick < 72) begin
                    send_request(ACT_RESIZE, resize_size(), where, reply);
                    if (reply.status == STAT_OK && reply.copy != 0)
                        live_blocks[slot] = reply.addr;
                end else begin
                    send_request(ACT_FREE, $urandom(), where, reply);
                    live_blocks.delete(slot);
                end
            end
        end
    endtask

    initial begin
        ledger         = new();
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = ACT_ALLOC_ZERO;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        allow_stale    = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        run_directed();
        for (int unsigned p = 0; p < PHASES; p++) begin
            write_slab_limit(LIMIT_W'(PHASE_LIMIT[p]));
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 59;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 59;
                end
                default: begin
                    send_idle_pct  = 17;
                    recv_stall_pct = 17;
                end
            endcase
            allow_stale = (p == PHASES - 1);
            run_random(PHASE_ITEMS[p]);
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        drain_results();
        repeat (10) @(negedge aclk);
        if (ledger.errors == 0 && ledger.owed.size() == 0) begin
            $display("size_class_slab_allocator_core verification clean");
        end else begin
            $display("size_class_slab_allocator_core verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/scsa_pkg.sv
hw/rtl/scsa_ram.sv
hw/rtl/scsa_ctrl.sv
hw/rtl/size_class_slab_allocator_core.sv
test/slab_ledger_pkg.sv
test/size_class_slab_allocator_core_tb.sv
